>>> design/rwrf_pkg.sv
// rwrf_pkg: shared constants, types and helpers of the rgb window rank filter
// no dependencies; imported by every module of the block except rwrf_queue
package rwrf_pkg;

  // window geometry
  localparam int WIN       = 3;
  localparam int TAPS      = WIN * WIN;
  localparam int MED_IDX   = TAPS / 2;
  localparam int RANK_W    = $clog2(TAPS);
  localparam int RING_ROWS = 2 * WIN;
  localparam int BANK_W    = $clog2(RING_ROWS);

  // field widths
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int GEOM_W     = 13;

  // defaults and queue depths
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CMD_DEPTH     = 4;
  localparam int RES_DEPTH     = 8;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [CH_W-1:0]     CH_MAX     = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_DILATE,
    MODE_ERODE,
    MODE_GRADIENT,
    MODE_MEDIAN
  } mode_t;

  typedef enum logic {
    OP_PIXEL,
    OP_DRAIN
  } opcode_t;

  typedef logic [BANK_W-1:0] bank_t;

  // one request from the front part to the line store
  typedef struct packed {
    logic                 we;
    bank_t                wbank;
    logic [PIX_W-1:0]     pix;
    logic                 emit;
    bank_t [WIN-1:0]      rbank;
    logic                 first;
    logic                 last;
    mode_t                mode;
  } cmd_t;

  // control travelling beside a gathered window
  typedef struct packed {
    logic  valid;
    logic  last;
    mode_t mode;
  } stage_t;

  // one result
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } res_t;

  function automatic bank_t bank_inc(bank_t b);
    return (b == bank_t'(RING_ROWS - 1)) ? '0 : bank_t'(b + 1'b1);
  endfunction

  function automatic bank_t bank_dec(bank_t b);
    return (b == '0) ? bank_t'(RING_ROWS - 1) : bank_t'(b - 1'b1);
  endfunction

endpackage

>>> design/rwrf_queue.sv
// rwrf_queue: small first-in first-out queue of flat words
// depends on nothing; used between front and line store and for results
module rwrf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       not_empty,
  output logic                       space,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr_r + 1'b1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

  assign rdata     = slot_r[rptr_r];
  assign not_empty = (cnt_r != '0);
  assign space     = (cnt_r != CNT_W'(DEPTH));
  assign count     = cnt_r;

endmodule

>>> design/rwrf_front.sv
// rwrf_front: configuration registers, frame position tracking and request build
// depends on rwrf_pkg
module rwrf_front #(
  parameter int MAX_WIDTH = rwrf_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [rwrf_pkg::CH_W-1:0]           in_red_in,
  input  logic [rwrf_pkg::CH_W-1:0]           in_green_in,
  input  logic [rwrf_pkg::CH_W-1:0]           in_blue_in,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rwrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwrf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                cmd_space,
  output logic                                cmd_push,
  output rwrf_pkg::cmd_t                      cmd,
  output logic [$clog2(MAX_WIDTH)-1:0]        cmd_wcol,
  output logic [$clog2(MAX_WIDTH)-1:0]        cmd_rcol
);
  import rwrf_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = HEIGHT_W;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  mode_t               mode_r;

  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  bank_t            in_bank_r, in_bank_nxt, out_bank_r, out_bank_nxt;

  logic [GEOM_W-1:0]   width_ext, w_eff, w_m1;
  logic [COL_W-1:0]    wlast;
  logic [HEIGHT_W-1:0] h_eff, hlast;
  logic accept, is_pix, frame_in, out_live, lag_ok;
  logic do_write, do_emit, emit_drain, is_last, geom_wr;

  // effective geometry
  always_comb begin
    width_ext = GEOM_W'(width_r);
    if (width_r == '0) begin
      w_eff = GEOM_W'(1);
    end else if (width_ext > GEOM_W'(MAX_WIDTH)) begin
      w_eff = GEOM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    w_m1  = GEOM_W'(w_eff - 1'b1);
    wlast = w_m1[COL_W-1:0];
    h_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
    hlast = HEIGHT_W'(h_eff - 1'b1);
  end

  // item classification
  assign in_ready   = cmd_space;
  assign cfg_ready  = 1'b1;
  assign accept     = in_valid && in_ready;
  assign is_pix     = (opcode_t'(in_opcode) == OP_PIXEL);
  assign frame_in   = (in_row_r >= h_eff);
  assign out_live   = (out_row_r < h_eff);
  assign lag_ok     = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
  assign do_write   = accept && is_pix && !frame_in;
  assign emit_drain = accept && !is_pix && frame_in && out_live;
  assign do_emit    = (do_write && lag_ok && out_live) || emit_drain;
  assign is_last    = emit_drain && (out_row_r == hlast) && (out_col_r == wlast);
  assign geom_wr    = cfg_valid && ((cfg_index == CFG_IMAGE_WIDTH) ||
                                    (cfg_index == CFG_IMAGE_HEIGHT));

  // position counters
  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_bank_nxt  = in_bank_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_bank_nxt = out_bank_r;
    priority if (geom_wr || (do_emit && is_last)) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_bank_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_bank_nxt = '0;
    end else begin
      if (do_write) begin
        if (in_col_r == wlast) begin
          in_col_nxt  = '0;
          in_row_nxt  = ROW_W'(in_row_r + 1'b1);
          in_bank_nxt = bank_inc(in_bank_r);
        end else begin
          in_col_nxt = COL_W'(in_col_r + 1'b1);
        end
      end
      if (do_emit) begin
        if (out_col_r == wlast) begin
          out_col_nxt  = '0;
          out_row_nxt  = ROW_W'(out_row_r + 1'b1);
          out_bank_nxt = bank_inc(out_bank_r);
        end else begin
          out_col_nxt = COL_W'(out_col_r + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_bank_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_bank_r <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_bank_r  <= in_bank_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_bank_r <= out_bank_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mode_r   <= MODE_DILATE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        CFG_FILTER_MODE:  mode_r   <= mode_t'(cfg_data[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // request towards the line store, rows and columns clamped at the edges
  always_comb begin
    cmd          = '0;
    cmd.we       = do_write;
    cmd.wbank    = in_bank_r;
    cmd.pix      = {in_red_in, in_green_in, in_blue_in};
    cmd.emit     = do_emit;
    cmd.rbank[0] = (out_row_r == '0) ? out_bank_r : bank_dec(out_bank_r);
    cmd.rbank[1] = out_bank_r;
    cmd.rbank[2] = (out_row_r == hlast) ? out_bank_r : bank_inc(out_bank_r);
    cmd.first    = (out_col_r == '0);
    cmd.last     = is_last;
    cmd.mode     = mode_r;
  end

  assign cmd_push = do_write || do_emit;
  assign cmd_wcol = in_col_r;
  assign cmd_rcol = (out_col_r == wlast) ? out_col_r : COL_W'(out_col_r + 1'b1);

endmodule

>>> design/rwrf_lines.sv
// rwrf_lines: row bank memories and the sliding window register
// depends on rwrf_pkg
module rwrf_lines #(
  parameter int MAX_WIDTH = rwrf_pkg::MAX_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cmd_valid,
  input  rwrf_pkg::cmd_t                              cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0]                cmd_wcol,
  input  logic [$clog2(MAX_WIDTH)-1:0]                cmd_rcol,
  input  logic                                        credit_ok,
  output logic                                        cmd_pop,
  output logic [1:0]                                  busy_cnt,
  output rwrf_pkg::stage_t                            win_ctl,
  output logic [rwrf_pkg::TAPS-1:0][rwrf_pkg::PIX_W-1:0] win
);
  import rwrf_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam logic [COL_W-1:0] ZERO_COL = '0;

  logic [PIX_W-1:0] rd_x [RING_ROWS];
  logic [PIX_W-1:0] rd_z [RING_ROWS];

  logic             p1_v_r, p2_v_r;
  bank_t [WIN-1:0]  p1_rbank_r;
  logic [WIN-1:0]   p1_fwdx_r, p1_fwd0_r;
  logic [PIX_W-1:0] p1_pix_r;
  logic             p1_first_r, p1_last_r, p2_last_r;
  mode_t            p1_mode_r, p2_mode_r;

  logic [PIX_W-1:0] win_r [WIN][WIN];
  logic [PIX_W-1:0] colx [WIN];
  logic [PIX_W-1:0] col0 [WIN];

  assign cmd_pop = cmd_valid && (!cmd.emit || credit_ok);

  // row banks: one write port, reads at the fetch column and at column zero
  for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rdx_r, rdz_r;
    always_ff @(posedge clk) begin
      if (cmd_pop && cmd.we && (cmd.wbank == bank_t'(b))) begin
        mem[cmd_wcol] <= cmd.pix;
      end
      rdx_r <= mem[cmd_rcol];
      rdz_r <= mem[ZERO_COL];
    end
    assign rd_x[b] = rdx_r;
    assign rd_z[b] = rdz_r;
  end

  // fetch stage control, with forwarding of a pixel written in the same request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd_pop && cmd.emit;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < WIN; k++) begin
      p1_fwdx_r[k] <= cmd.we && (cmd.wbank == cmd.rbank[k]) && (cmd_wcol == cmd_rcol);
      p1_fwd0_r[k] <= cmd.we && (cmd.wbank == cmd.rbank[k]) && (cmd_wcol == ZERO_COL);
    end
    p1_rbank_r <= cmd.rbank;
    p1_pix_r   <= cmd.pix;
    p1_first_r <= cmd.first;
    p1_last_r  <= cmd.last;
    p1_mode_r  <= cmd.mode;
    p2_last_r  <= p1_last_r;
    p2_mode_r  <= p1_mode_r;
  end

  // new columns picked from the banks of the window rows
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      colx[k] = p1_fwdx_r[k] ? p1_pix_r : rd_x[p1_rbank_r[k]];
      col0[k] = p1_fwd0_r[k] ? p1_pix_r : rd_z[p1_rbank_r[k]];
    end
  end

  // window shift, left edge replicated at the start of a row
  always_ff @(posedge clk) begin
    if (p1_v_r) begin
      for (int k = 0; k < WIN; k++) begin
        if (p1_first_r) begin
          win_r[k][0] <= col0[k];
          win_r[k][1] <= col0[k];
        end else begin
          win_r[k][0] <= win_r[k][1];
          win_r[k][1] <= win_r[k][2];
        end
        win_r[k][2] <= colx[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN; j++) begin
        win[k*WIN + j] = win_r[k][j];
      end
    end
  end

  assign win_ctl.valid = p2_v_r;
  assign win_ctl.last  = p2_last_r;
  assign win_ctl.mode  = p2_mode_r;
  assign busy_cnt      = {1'b0, p1_v_r} + {1'b0, p2_v_r};

endmodule

>>> design/rwrf_rank.sv
// rwrf_rank: per channel maximum, minimum, inverted gradient or median of the window
// depends on rwrf_pkg
module rwrf_rank (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  rwrf_pkg::stage_t                            win_ctl,
  input  logic [rwrf_pkg::TAPS-1:0][rwrf_pkg::PIX_W-1:0] win,
  output logic                                        res_valid,
  output rwrf_pkg::res_t                              res
);
  import rwrf_pkg::*;

  logic  p3_v_r, p3_last_r;
  mode_t p3_mode_r;
  logic [CH_W-1:0] ch_res [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else begin
      p3_v_r <= win_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    p3_last_r <= win_ctl.last;
    p3_mode_r <= win_ctl.mode;
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    logic [CH_W-1:0]   v [TAPS];
    logic [CH_W-1:0]   mx, mn, med;
    logic [RANK_W-1:0] rank [TAPS];
    logic [TAPS-1:0]   sel;
    logic [CH_W-1:0]   v_r [TAPS];
    logic [CH_W-1:0]   mx_r, mn_r;
    logic [TAPS-1:0]   sel_r;

    // extremes and the rank of each tap, ties broken by tap order
    always_comb begin
      mx = '0;
      mn = CH_MAX;
      for (int i = 0; i < TAPS; i++) begin
        v[i] = win[i][(NUM_CH-1-ch)*CH_W +: CH_W];
      end
      for (int i = 0; i < TAPS; i++) begin
        if (v[i] > mx) mx = v[i];
        if (v[i] < mn) mn = v[i];
      end
      for (int i = 0; i < TAPS; i++) begin
        rank[i] = '0;
        for (int j = 0; j < TAPS; j++) begin
          if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
            rank[i] = RANK_W'(rank[i] + 1'b1);
          end
        end
        sel[i] = (rank[i] == RANK_W'(MED_IDX));
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < TAPS; i++) begin
        v_r[i] <= v[i];
      end
      mx_r  <= mx;
      mn_r  <= mn;
      sel_r <= sel;
    end

    // median pick and mode select
    always_comb begin
      med = '0;
      for (int i = 0; i < TAPS; i++) begin
        med = med | (sel_r[i] ? v_r[i] : '0);
      end
      unique case (p3_mode_r)
        MODE_DILATE:   ch_res[ch] = mx_r;
        MODE_ERODE:    ch_res[ch] = mn_r;
        MODE_GRADIENT: ch_res[ch] = CH_W'(CH_MAX - CH_W'(mx_r - mn_r));
        MODE_MEDIAN:   ch_res[ch] = med;
      endcase
    end
  end

  assign res_valid = p3_v_r;
  assign res.red   = ch_res[0];
  assign res.green = ch_res[1];
  assign res.blue  = ch_res[2];
  assign res.last  = p3_last_r;

endmodule

>>> design/rgb_window_rank_filter.sv
// rgb_window_rank_filter: top level of the 3x3 rgb rank filter
// depends on rwrf_pkg, rwrf_front, rwrf_queue, rwrf_lines and rwrf_rank
//
// Takes one request per clock on the in_ channel, pixel or drain, and keeps doing so
// as long as the request queue has room. The front tracks the frame position and builds
// row and column addresses with edge clamping; a four deep queue feeds the line store,
// six row banks of MAX_WIDTH pixels each with one write and two reads per clock; the
// window then passes through a rank unit into an eight deep result queue. The rate is
// set by the single line store access per request.
module rgb_window_rank_filter #(
  parameter int MAX_WIDTH = rwrf_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [rwrf_pkg::CH_W-1:0]       in_red_in,
  input  logic [rwrf_pkg::CH_W-1:0]       in_green_in,
  input  logic [rwrf_pkg::CH_W-1:0]       in_blue_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rwrf_pkg::CH_W-1:0]       out_red_out,
  output logic [rwrf_pkg::CH_W-1:0]       out_green_out,
  output logic [rwrf_pkg::CH_W-1:0]       out_blue_out,
  output logic                            out_frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rwrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwrf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rwrf_pkg::*;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CMD_W     = $bits(cmd_t) + 2 * COL_W;
  localparam int RES_W     = $bits(res_t);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam int CRD_W     = RES_CNT_W + 1;

  cmd_t             f_cmd, q_cmd;
  logic [COL_W-1:0] f_wcol, f_rcol, q_wcol, q_rcol;
  logic             f_push, q_valid, q_space, q_pop;
  logic [CMD_W-1:0] q_rdata;
  logic [CMD_CNT_W-1:0] q_count;

  logic [1:0]        busy_cnt;
  stage_t            win_ctl;
  logic [TAPS-1:0][PIX_W-1:0] win;
  logic              res_valid, credit_ok;
  res_t              res, res_head;
  logic [RES_W-1:0]  res_rdata;
  logic              res_space;
  logic [RES_CNT_W-1:0] res_count;
  logic [CRD_W-1:0]  pending;

  // front: configuration and request build
  rwrf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_red_in  (in_red_in),
    .in_green_in(in_green_in),
    .in_blue_in (in_blue_in),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_space  (q_space),
    .cmd_push   (f_push),
    .cmd        (f_cmd),
    .cmd_wcol   (f_wcol),
    .cmd_rcol   (f_rcol)
  );

  // request queue between front and line store
  rwrf_queue #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .wdata    ({f_cmd, f_wcol, f_rcol}),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .not_empty(q_valid),
    .space    (q_space),
    .count    (q_count)
  );

  assign {q_cmd, q_wcol, q_rcol} = q_rdata;

  // results in flight, plus the one about to issue, may never outnumber result slots
  assign pending   = CRD_W'(res_count) + CRD_W'(busy_cnt) + CRD_W'(res_valid)
                   + CRD_W'(q_count != '0);
  assign credit_ok = (pending <= CRD_W'(RES_DEPTH));

  // line store and window
  rwrf_lines #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_valid),
    .cmd      (q_cmd),
    .cmd_wcol (q_wcol),
    .cmd_rcol (q_rcol),
    .credit_ok(credit_ok),
    .cmd_pop  (q_pop),
    .busy_cnt (busy_cnt),
    .win_ctl  (win_ctl),
    .win      (win)
  );

  // rank unit
  rwrf_rank u_rank (
    .clk      (clk),
    .rst_n    (rst_n),
    .win_ctl  (win_ctl),
    .win      (win),
    .res_valid(res_valid),
    .res      (res)
  );

  // result queue
  rwrf_queue #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid && res_space),
    .wdata    (res),
    .pop      (out_valid && out_ready),
    .rdata    (res_rdata),
    .not_empty(out_valid),
    .space    (res_space),
    .count    (res_count)
  );

  assign res_head       = res_t'(res_rdata);
  assign out_red_out    = res_head.red;
  assign out_green_out  = res_head.green;
  assign out_blue_out   = res_head.blue;
  assign out_frame_last = res_head.last;

endmodule

>>> sim/rgb_window_rank_filter_chk.sv
// rgb_window_rank_filter_chk: watches the request, result and register channels,
// predicts each filtered pixel and compares it with what the block returns
// depends on rwrf_pkg
`timescale 1ns / 1ps

module rgb_window_rank_filter_chk
  import rwrf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [CH_W-1:0]       in_red_in,
  input  logic [CH_W-1:0]       in_green_in,
  input  logic [CH_W-1:0]       in_blue_in,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CH_W-1:0]       out_red_out,
  input  logic [CH_W-1:0]       out_green_out,
  input  logic [CH_W-1:0]       out_blue_out,
  input  logic                  out_frame_last,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pixels_due,
  output int                    mismatches
);

  localparam int ROW_CAP = 1024;

  // model copy of the block state
  logic [PIX_W-1:0]    rows [RING_ROWS*ROW_CAP];
  logic [PIX_W-1:0]    win  [TAPS];
  logic [WIDTH_W-1:0]  width_reg = WIDTH_RST;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RST;
  mode_t               mode_reg = MODE_DILATE;
  int                  col_pos = 0;
  int                  row_pos = 0;
  int                  next_out = 0;
  res_t                due_q[$];

  assign pixels_due = due_q.size();

  initial begin
    mismatches = 0;
    foreach (rows[i]) rows[i] = '0;
    foreach (win[i]) win[i] = '0;
  end

  function automatic int frame_w();
    if (width_reg == 0) return 1;
    if (width_reg > ROW_CAP) return ROW_CAP;
    return int'(width_reg);
  endfunction

  function automatic int frame_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // rank of one channel over the gathered window
  function automatic logic [CH_W-1:0] rank_channel(int shift);
    logic [CH_W-1:0] v [TAPS];
    logic [CH_W-1:0] hi_v, lo_v, t;
    hi_v = 8'd0;
    lo_v = CH_MAX;
    for (int i = 0; i < TAPS; i++) begin
      v[i] = win[i][shift +: CH_W];
      if (v[i] > hi_v) hi_v = v[i];
      if (v[i] < lo_v) lo_v = v[i];
    end
    case (mode_reg)
      MODE_DILATE:   return hi_v;
      MODE_ERODE:    return lo_v;
      MODE_GRADIENT: return CH_MAX - (hi_v - lo_v);
      default: begin
        for (int i = 1; i < TAPS; i++)
          for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
            t = v[j]; v[j] = v[j-1]; v[j-1] = t;
          end
        return v[MED_IDX];
      end
    endcase
  endfunction

  // gather the window of the next output pixel and queue its value
  task automatic push_filtered(bit last);
    int   w, h, r, c, yy, xx;
    res_t e;
    w = frame_w();
    h = frame_h();
    r = next_out / w;
    c = next_out % w;
    for (int i = 0; i < WIN; i++) begin
      yy = clip(r - WIN/2 + i, 0, h - 1);
      for (int j = 0; j < WIN; j++) begin
        xx = clip(c - WIN/2 + j, 0, w - 1);
        win[i*WIN + j] = rows[(yy % RING_ROWS)*ROW_CAP + xx];
      end
    end
    e.red   = rank_channel(16);
    e.green = rank_channel(8);
    e.blue  = rank_channel(0);
    e.last  = last;
    due_q.push_back(e);
    next_out++;
  endtask

  task automatic restart_frame();
    col_pos = 0;
    row_pos = 0;
    next_out = 0;
  endtask

  // one accepted request
  task automatic take_request();
    int w, h, total, lag, col, n;
    w = frame_w();
    h = frame_h();
    total = w * h;
    lag = (WIN/2) * w + WIN/2;
    if (opcode_t'(in_opcode) == OP_DRAIN) begin
      if (row_pos >= h && next_out < total) begin
        if (next_out + 1 == total) begin
          push_filtered(1'b1);
          restart_frame();
        end else begin
          push_filtered(1'b0);
        end
      end
    end else if (row_pos < h) begin
      col = col_pos % w;
      n = row_pos * w + col;
      rows[(row_pos % RING_ROWS)*ROW_CAP + col] = {in_red_in, in_green_in, in_blue_in};
      col_pos = col + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (n >= lag && next_out < total) push_filtered(1'b0);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      // results first: none can belong to a request of the same edge
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result r=%0d g=%0d b=%0d last=%0b",
                     out_red_out, out_green_out, out_blue_out, out_frame_last);
        end else begin
          e = due_q.pop_front();
          if (e.red !== out_red_out || e.green !== out_green_out ||
              e.blue !== out_blue_out || e.last !== out_frame_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                       e.red, e.green, e.blue, e.last,
                       out_red_out, out_green_out, out_blue_out, out_frame_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            width_reg = cfg_data[WIDTH_W-1:0];
            restart_frame();
          end
          CFG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[HEIGHT_W-1:0];
            restart_frame();
          end
          CFG_FILTER_MODE: mode_reg = mode_t'(cfg_data[MODE_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_request();
    end
  end

endmodule

>>> sim/rgb_window_rank_filter_tb.sv
// rgb_window_rank_filter_tb: drives frames, drains and register writes into the
// filter and gives the verdict; depends on rwrf_pkg and rgb_window_rank_filter_chk
`timescale 1ns / 1ps

module rgb_window_rank_filter_tb;
  import rwrf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE = 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = 1'b0;
  logic [CH_W-1:0]       in_red_in = '0;
  logic [CH_W-1:0]       in_green_in = '0;
  logic [CH_W-1:0]       in_blue_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CH_W-1:0]       out_red_out;
  logic [CH_W-1:0]       out_green_out;
  logic [CH_W-1:0]       out_blue_out;
  logic                  out_frame_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    pixels_due;
  int                    mismatches;
  int                    cycles = 0;
  int                    sent = 0;
  int                    cur_w, cur_h;
  bit                    calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rgb_window_rank_filter i_dut (.*);

  rgb_window_rank_filter_chk i_chk (.*);

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure in bursts
  initial begin
    @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // one request, held until taken, with an occasional gap after it
  task automatic send(opcode_t op, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                      logic [CH_W-1:0] b);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_pixel();
    send(OP_PIXEL, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
  endtask

  task automatic send_drain();
    send(OP_DRAIN, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
  endtask

  // wait until the block has nothing left in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // geometry as the block sees it
  task automatic set_geometry(int wv, int hv);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(wv));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(hv));
    cur_w = wv % 2048;
    cur_w = (cur_w == 0) ? 1 : ((cur_w > 1024) ? 1024 : cur_w);
    cur_h = (hv == 0) ? 1 : hv;
  endtask

  // whole frame then the drains that flush it; noise adds ignored requests
  task automatic run_frame(bit noise);
    int total, lag, drains;
    total = cur_w * cur_h;
    lag = cur_w + 1;
    drains = (total > lag) ? lag : total;
    for (int i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 19) == 0) send_drain();
      send_pixel();
    end
    if (noise && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) send_pixel();
    for (int i = 0; i < drains; i++) begin
      if (noise && $urandom_range(0, 15) == 0) send_pixel();
      send_drain();
    end
    if (noise && $urandom_range(0, 3) == 0) send(OP_DRAIN, 8'd0, 8'd0, 8'd0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 3x3 median frame with field extremes and the ignored cases
    write_reg(CFG_SPARE, '1);
    write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_MEDIAN));
    set_geometry(3, 3);
    send(OP_DRAIN, 8'hff, 8'hff, 8'hff);
    send(OP_PIXEL, 8'h00, 8'hff, 8'h55);
    send(OP_PIXEL, 8'hff, 8'h00, 8'haa);
    send(OP_PIXEL, 8'h55, 8'haa, 8'h00);
    send(OP_PIXEL, 8'haa, 8'h55, 8'hff);
    send(OP_PIXEL, 8'h01, 8'h80, 8'hfe);
    send(OP_PIXEL, 8'hfe, 8'h7f, 8'h01);
    send(OP_PIXEL, 8'h80, 8'h01, 8'h7f);
    send(OP_PIXEL, 8'h7f, 8'hfe, 8'h80);
    send(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    repeat (4) send(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    send(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // geometry extremes, including the values that act as limits
    write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_ERODE));
    set_geometry(13'h1fff, 0);
    run_frame(1'b1);
    wait_idle();
    write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_DILATE));
    set_geometry(0, 2);
    run_frame(1'b1);
    wait_idle();
    write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_MEDIAN));
    set_geometry(1, 40);
    run_frame(1'b0);
    wait_idle();

    // random small frames in every mode
    sent = 0;
    while (sent < 700) begin
      write_reg(CFG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) != 0) set_geometry($urandom_range(1, 10), $urandom_range(1, 8));
      run_frame($urandom_range(0, 3) == 0);
      wait_idle();
    end

    // last stretch with no idling
    calm = 1'b1;
    write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_GRADIENT));
    set_geometry(7, 5);
    run_frame(1'b0);
    run_frame(1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_due != 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pixels_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
